[rtl/lmsd_pkg.sv]
// lmsd_pkg: shared types and constants for the LED matrix scan driver.
// Holds the queue word layout, the operation codes and the back-end state enum.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package lmsd_pkg;

  localparam int LEVEL_W    = 8;  // width of one input colour channel
  localparam int X_W        = 5;  // width of a pixel column field
  localparam int Y_W        = 4;  // width of a pixel row field
  localparam int RGB_W      = 3;  // one data pin per colour
  localparam int ROW_ADDR_W = 3;  // panel row address pins
  localparam int COL_OUT_W  = 5;  // reported shift column

  localparam int Q_DEPTH  = 2;
  localparam int QPTR_W   = $clog2(Q_DEPTH);
  localparam int QCOUNT_W = QPTR_W + 1;

  localparam logic KIND_TICK = 1'b1;

  typedef enum logic {
    OP_WRITE,
    OP_TICK
  } op_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } back_state_t;

  // One classified word on its way from the front end to the back end.
  typedef struct packed {
    op_t                op;
    logic               bottom;
    logic [Y_W-1:0]     row;
    logic [X_W-1:0]     col;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage
`default_nettype wire

[rtl/led_matrix_pwm_scan_driver_unit.sv]
// LED matrix PWM scan driver: frame buffer plus column-shift sequencer.
// A tick word goes through the queue, the read stage and the result register.
// One word per cycle when not stalled; each tick reads each half memory once.
// Reset: synchronous, active low; then a clear sweep writes black into all
// HALF_ROWS*PANEL_COLUMNS words of both halves while in_stall stays high.
// Writes give no result; writes outside the panel are taken and dropped.
`timescale 1ns / 1ps
`default_nettype none
module led_matrix_pwm_scan_driver_unit #(
  parameter int PANEL_COLUMNS = 32,
  parameter int HALF_ROWS     = 8,
  parameter int COLOR_BITS    = 2
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_kind,
  input  wire logic [lmsd_pkg::X_W-1:0]        in_column_x,
  input  wire logic [lmsd_pkg::Y_W-1:0]        in_row_y,
  input  wire logic [lmsd_pkg::LEVEL_W-1:0]    in_red_level,
  input  wire logic [lmsd_pkg::LEVEL_W-1:0]    in_green_level,
  input  wire logic [lmsd_pkg::LEVEL_W-1:0]    in_blue_level,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [lmsd_pkg::RGB_W-1:0]           out_top_rgb,
  output logic [lmsd_pkg::RGB_W-1:0]           out_bottom_rgb,
  output logic [lmsd_pkg::ROW_ADDR_W-1:0]      out_row_address,
  output logic [lmsd_pkg::COL_OUT_W-1:0]       out_shift_column,
  output logic                                 out_latch_row,
  output logic                                 out_frame_end
);

  lmsd_pkg::q_entry_t front_entry;
  lmsd_pkg::q_head_t  q_head;
  logic               front_keep;
  logic               q_full;
  logic               q_pop;
  logic               clearing;
  logic               accept;

  // hold off new words during the clear sweep and while the queue is full
  assign in_stall = clearing || q_full;
  assign accept   = in_valid && !in_stall;

  // front: decode kind, range check, pick half, shorten channels
  lmsd_front #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .HALF_ROWS     (HALF_ROWS),
    .COLOR_BITS    (COLOR_BITS)
  ) u_front (
    .in_kind        (in_kind),
    .in_column_x    (in_column_x),
    .in_row_y       (in_row_y),
    .in_red_level   (in_red_level),
    .in_green_level (in_green_level),
    .in_blue_level  (in_blue_level),
    .entry          (front_entry),
    .keep           (front_keep)
  );

  // queue: decouple acceptance from the result handshake; order is kept,
  // so a write is always seen by every later tick
  lmsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept && front_keep),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head)
  );

  // back: memories, scan counters, read stage and result register
  lmsd_back #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .HALF_ROWS     (HALF_ROWS),
    .COLOR_BITS    (COLOR_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .pop              (q_pop),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_top_rgb      (out_top_rgb),
    .out_bottom_rgb   (out_bottom_rgb),
    .out_row_address  (out_row_address),
    .out_shift_column (out_shift_column),
    .out_latch_row    (out_latch_row),
    .out_frame_end    (out_frame_end)
  );

endmodule
`default_nettype wire

[rtl/lmsd_front.sv]
// lmsd_front: classifies incoming words into pixel writes and scan ticks.
// Drops writes outside the panel, picks the half and shortens the channels.
// Depends on lmsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lmsd_front #(
  parameter int PANEL_COLUMNS = 32,
  parameter int HALF_ROWS     = 8,
  parameter int COLOR_BITS    = 2
) (
  input  wire logic                         in_kind,
  input  wire logic [lmsd_pkg::X_W-1:0]     in_column_x,
  input  wire logic [lmsd_pkg::Y_W-1:0]     in_row_y,
  input  wire logic [lmsd_pkg::LEVEL_W-1:0] in_red_level,
  input  wire logic [lmsd_pkg::LEVEL_W-1:0] in_green_level,
  input  wire logic [lmsd_pkg::LEVEL_W-1:0] in_blue_level,
  output lmsd_pkg::q_entry_t                entry,
  output logic                              keep
);

  localparam int SHIFT = lmsd_pkg::LEVEL_W - COLOR_BITS;

  logic [7:0] x_ext;
  logic [6:0] y_ext;
  logic [6:0] y_low;
  logic       is_tick;
  logic       in_range;
  logic       bottom;

  always_comb begin
    x_ext    = {3'b0, in_column_x};
    y_ext    = {3'b0, in_row_y};
    is_tick  = (in_kind == lmsd_pkg::KIND_TICK);
    in_range = (x_ext < 8'(PANEL_COLUMNS)) && (y_ext < 7'(2 * HALF_ROWS));
    bottom   = (y_ext >= 7'(HALF_ROWS));
    y_low    = bottom ? (y_ext - 7'(HALF_ROWS)) : y_ext;

    keep         = is_tick || in_range;
    entry.op     = is_tick ? lmsd_pkg::OP_TICK : lmsd_pkg::OP_WRITE;
    entry.bottom = bottom;
    entry.row    = y_low[lmsd_pkg::Y_W-1:0];
    entry.col    = in_column_x;
    // keep the top COLOR_BITS bits of each channel
    entry.red    = in_red_level >> SHIFT;
    entry.green  = in_green_level >> SHIFT;
    entry.blue   = in_blue_level >> SHIFT;
  end

endmodule
`default_nettype wire

[rtl/lmsd_queue.sv]
// lmsd_queue: short FIFO between the front end and the back end.
// Lets the front accept while the back waits on the result side.
// Depends on lmsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lmsd_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire lmsd_pkg::q_entry_t  push_entry,
  output logic                     full,
  input  wire logic                pop,
  output lmsd_pkg::q_head_t        head
);

  lmsd_pkg::q_entry_t                slots_r [lmsd_pkg::Q_DEPTH];
  logic [lmsd_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [lmsd_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [lmsd_pkg::QCOUNT_W-1:0]     count_r, count_nxt;
  logic                              do_push;
  logic                              do_pop;

  always_comb begin
    full       = (count_r == lmsd_pkg::QCOUNT_W'(lmsd_pkg::Q_DEPTH));
    head.valid = (count_r != '0);
    head.entry = slots_r[rd_ptr_r];
    do_push    = push && !full;
    do_pop     = pop && head.valid;
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

[rtl/lmsd_back.sv]
// lmsd_back: pixel memories, scan sequencer and result register.
// Clears both halves after reset, then carries out writes and ticks in order.
// Depends on lmsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lmsd_back #(
  parameter int PANEL_COLUMNS = 32,
  parameter int HALF_ROWS     = 8,
  parameter int COLOR_BITS    = 2
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire lmsd_pkg::q_head_t               head,
  output logic                                 pop,
  output logic                                 clearing,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [lmsd_pkg::RGB_W-1:0]           out_top_rgb,
  output logic [lmsd_pkg::RGB_W-1:0]           out_bottom_rgb,
  output logic [lmsd_pkg::ROW_ADDR_W-1:0]      out_row_address,
  output logic [lmsd_pkg::COL_OUT_W-1:0]       out_shift_column,
  output logic                                 out_latch_row,
  output logic                                 out_frame_end
);

  localparam int DEPTH  = HALF_ROWS * PANEL_COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(HALF_ROWS);
  localparam int COL_W  = $clog2(PANEL_COLUMNS);
  localparam int WORD_W = 3 * COLOR_BITS;

  // pixel memories, word = {red, green, blue}
  logic [WORD_W-1:0] top_mem    [DEPTH];
  logic [WORD_W-1:0] bottom_mem [DEPTH];
  logic [WORD_W-1:0] top_rd_r;
  logic [WORD_W-1:0] bottom_rd_r;

  lmsd_pkg::back_state_t state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;

  logic [COL_W-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [COLOR_BITS-1:0] lvl_r, lvl_nxt;

  logic                  s1_valid_r, s1_valid_nxt;
  logic [COLOR_BITS-1:0] s1_lvl_r;
  logic [ROW_W-1:0]      s1_row_r;
  logic [COL_W-1:0]      s1_col_r;
  logic                  s1_latch_r;
  logic                  s1_frame_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [lmsd_pkg::RGB_W-1:0]      top_rgb_r, bottom_rgb_r;
  logic [lmsd_pkg::ROW_ADDR_W-1:0] row_addr_r;
  logic [lmsd_pkg::COL_OUT_W-1:0]  shift_col_r;
  logic                  latch_r, frame_r;

  logic                  s1_move;
  logic                  tick_room;
  logic                  tick_go;
  logic                  wr_go;
  logic                  last_col, last_row, last_lvl;
  logic [ROW_W+3:0]      wr_row_ext;
  logic [COL_W+4:0]      wr_col_ext;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     scan_addr;
  logic [WORD_W-1:0]     wr_word;
  logic                  top_we, bottom_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [WORD_W-1:0]     mem_wdata;
  logic [ROW_W+2:0]      s1_row_ext;
  logic [COL_W+4:0]      s1_col_ext;
  logic [lmsd_pkg::RGB_W-1:0] top_code, bottom_code;

  // next state of the clear sweep
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lmsd_pkg::ST_CLEAR: begin
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = lmsd_pkg::ST_RUN;
        end
      end
      lmsd_pkg::ST_RUN: state_nxt = lmsd_pkg::ST_RUN;
      default:          state_nxt = lmsd_pkg::ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    case (state_r)
      lmsd_pkg::ST_CLEAR: clearing = 1'b1;
      lmsd_pkg::ST_RUN:   clearing = 1'b0;
      default:            clearing = 1'b1;
    endcase
    clr_addr_nxt = clearing ? clr_addr_r + 1'b1 : '0;
  end

  always_comb begin
    s1_move   = s1_valid_r && (!out_valid_r || !out_stall);
    tick_room = !s1_valid_r || s1_move;
    pop       = head.valid && !clearing &&
                ((head.entry.op == lmsd_pkg::OP_WRITE) || tick_room);
    tick_go   = pop && (head.entry.op == lmsd_pkg::OP_TICK);
    wr_go     = pop && (head.entry.op == lmsd_pkg::OP_WRITE);

    wr_row_ext = {{ROW_W{1'b0}}, head.entry.row};
    wr_col_ext = {{COL_W{1'b0}}, head.entry.col};
    wr_addr    = ADDR_W'(wr_row_ext[ROW_W-1:0]) * ADDR_W'(PANEL_COLUMNS)
               + ADDR_W'(wr_col_ext[COL_W-1:0]);
    scan_addr  = ADDR_W'(row_r) * ADDR_W'(PANEL_COLUMNS) + ADDR_W'(col_r);
    wr_word    = {head.entry.red[COLOR_BITS-1:0],
                  head.entry.green[COLOR_BITS-1:0],
                  head.entry.blue[COLOR_BITS-1:0]};

    top_we    = clearing || (wr_go && !head.entry.bottom);
    bottom_we = clearing || (wr_go && head.entry.bottom);
    mem_waddr = clearing ? clr_addr_r : wr_addr;
    mem_wdata = clearing ? '0 : wr_word;

    // scan order: column fastest, then row, then PWM level
    last_col = (col_r == COL_W'(PANEL_COLUMNS - 1));
    last_row = (row_r == ROW_W'(HALF_ROWS - 1));
    last_lvl = (lvl_r == '1);
    col_nxt  = col_r;
    row_nxt  = row_r;
    lvl_nxt  = lvl_r;
    if (tick_go) begin
      if (!last_col) begin
        col_nxt = col_r + 1'b1;
      end else begin
        col_nxt = '0;
        if (!last_row) begin
          row_nxt = row_r + 1'b1;
        end else begin
          row_nxt = '0;
          lvl_nxt = last_lvl ? COLOR_BITS'(1) : lvl_r + 1'b1;
        end
      end
    end

    s1_valid_nxt  = tick_go || (s1_valid_r && !s1_move);
    out_valid_nxt = s1_move || (out_valid_r && out_stall);

    // a channel is lit when its stored level reaches the PWM level
    top_code = {top_rd_r[3*COLOR_BITS-1:2*COLOR_BITS] >= s1_lvl_r,
                top_rd_r[2*COLOR_BITS-1:COLOR_BITS] >= s1_lvl_r,
                top_rd_r[COLOR_BITS-1:0] >= s1_lvl_r};
    bottom_code = {bottom_rd_r[3*COLOR_BITS-1:2*COLOR_BITS] >= s1_lvl_r,
                   bottom_rd_r[2*COLOR_BITS-1:COLOR_BITS] >= s1_lvl_r,
                   bottom_rd_r[COLOR_BITS-1:0] >= s1_lvl_r};
    s1_row_ext = {3'b0, s1_row_r};
    s1_col_ext = {5'b0, s1_col_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lmsd_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      col_r       <= '0;
      row_r       <= '0;
      lvl_r       <= COLOR_BITS'(1);
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      lvl_r       <= lvl_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // tick metadata travels alongside the memory read
  always_ff @(posedge clk) begin
    if (tick_go) begin
      s1_lvl_r   <= lvl_r;
      s1_row_r   <= row_r;
      s1_col_r   <= col_r;
      s1_latch_r <= last_col;
      s1_frame_r <= last_col && last_row && last_lvl;
    end
    if (s1_move) begin
      top_rgb_r    <= top_code;
      bottom_rgb_r <= bottom_code;
      row_addr_r   <= s1_row_ext[lmsd_pkg::ROW_ADDR_W-1:0];
      shift_col_r  <= s1_col_ext[lmsd_pkg::COL_OUT_W-1:0];
      latch_r      <= s1_latch_r;
      frame_r      <= s1_frame_r;
    end
  end

  always_ff @(posedge clk) begin
    if (top_we) begin
      top_mem[mem_waddr] <= mem_wdata;
    end
    if (tick_go) begin
      top_rd_r <= top_mem[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (bottom_we) begin
      bottom_mem[mem_waddr] <= mem_wdata;
    end
    if (tick_go) begin
      bottom_rd_r <= bottom_mem[scan_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_top_rgb      = top_rgb_r;
  assign out_bottom_rgb   = bottom_rgb_r;
  assign out_row_address  = row_addr_r;
  assign out_shift_column = shift_col_r;
  assign out_latch_row    = latch_r;
  assign out_frame_end    = frame_r;

endmodule
`default_nettype wire

[rtl/lmsd_checker.sv]
// lmsd_checker: port-level checks on the scan driver's result channel.
// Bound to led_matrix_pwm_scan_driver_unit; depends on lmsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lmsd_checker #(
  parameter int PANEL_COLUMNS = 32
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [lmsd_pkg::RGB_W-1:0]      out_top_rgb,
  input wire logic [lmsd_pkg::RGB_W-1:0]      out_bottom_rgb,
  input wire logic [lmsd_pkg::ROW_ADDR_W-1:0] out_row_address,
  input wire logic [lmsd_pkg::COL_OUT_W-1:0]  out_shift_column,
  input wire logic                            out_latch_row,
  input wire logic                            out_frame_end
);

  localparam logic [lmsd_pkg::COL_OUT_W-1:0] LAST_COL =
    lmsd_pkg::COL_OUT_W'(PANEL_COLUMNS - 1);

  a_stalled_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_top_rgb) &&
    $stable(out_bottom_rgb) && $stable(out_row_address) &&
    $stable(out_shift_column) && $stable(out_latch_row) && $stable(out_frame_end))
    else $error("stalled result word changed");

  a_frame_end_latches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_latch_row)
    else $error("frame end without row latch");

  a_latch_on_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_latch_row |-> out_shift_column == LAST_COL)
    else $error("row latch away from last column");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind led_matrix_pwm_scan_driver_unit lmsd_checker #(
  .PANEL_COLUMNS (PANEL_COLUMNS)
) u_lmsd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_top_rgb      (out_top_rgb),
  .out_bottom_rgb   (out_bottom_rgb),
  .out_row_address  (out_row_address),
  .out_shift_column (out_shift_column),
  .out_latch_row    (out_latch_row),
  .out_frame_end    (out_frame_end)
);
`default_nettype wire

[tb/sv/tb_top.sv]
// tb_top: self-checking bench for the LED matrix PWM scan driver unit.
// Drives pixel writes and scan ticks, predicts every column shift and compares.
// Depends on lmsd_pkg and led_matrix_pwm_scan_driver_unit.
`timescale 1ns / 1ps
module tb_top;

  localparam int PANEL_COLUMNS = 32;
  localparam int HALF_ROWS     = 8;
  localparam int COLOR_BITS    = 2;
  localparam int HALF_PIXELS   = PANEL_COLUMNS * HALF_ROWS;
  localparam int PWM_TOP       = (1 << COLOR_BITS) - 1;
  localparam int RAND_WORDS    = 1700;
  localparam int DIR_WORDS     = 17;
  localparam int SHOW_FAULTS   = 10;

  // One stored pixel: each channel already cut down to COLOR_BITS.
  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } pixel_t;

  // One column shift as it leaves the block.
  typedef struct packed {
    logic [lmsd_pkg::RGB_W-1:0]      top;
    logic [lmsd_pkg::RGB_W-1:0]      bottom;
    logic [lmsd_pkg::ROW_ADDR_W-1:0] row;
    logic [lmsd_pkg::COL_OUT_W-1:0]  col;
    logic                            latch;
    logic                            frame_end;
  } shift_word_t;

  // One input word plus an optional hand-written shift for directed rows.
  typedef struct packed {
    lmsd_pkg::op_t                op;
    logic [lmsd_pkg::X_W-1:0]     x;
    logic [lmsd_pkg::Y_W-1:0]     y;
    logic [lmsd_pkg::LEVEL_W-1:0] r;
    logic [lmsd_pkg::LEVEL_W-1:0] g;
    logic [lmsd_pkg::LEVEL_W-1:0] b;
    logic                         typed;
    shift_word_t                  shift;
  } stim_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic                            in_kind;
  logic [lmsd_pkg::X_W-1:0]        in_column_x;
  logic [lmsd_pkg::Y_W-1:0]        in_row_y;
  logic [lmsd_pkg::LEVEL_W-1:0]    in_red_level;
  logic [lmsd_pkg::LEVEL_W-1:0]    in_green_level;
  logic [lmsd_pkg::LEVEL_W-1:0]    in_blue_level;
  logic                            out_valid;
  logic                            out_stall;
  logic [lmsd_pkg::RGB_W-1:0]      out_top_rgb;
  logic [lmsd_pkg::RGB_W-1:0]      out_bottom_rgb;
  logic [lmsd_pkg::ROW_ADDR_W-1:0] out_row_address;
  logic [lmsd_pkg::COL_OUT_W-1:0]  out_shift_column;
  logic                            out_latch_row;
  logic                            out_frame_end;

  // Shadow frame buffer and scan position of the predictor.
  pixel_t                top_shadow [HALF_PIXELS];
  pixel_t                bottom_shadow [HALF_PIXELS];
  logic [COLOR_BITS-1:0] pwm_now;
  logic [2:0]            row_now;
  logic [4:0]            col_now;

  shift_word_t pending_shifts [$];
  shift_word_t seen_shift;
  shift_word_t want_shift;
  int          fault_count = 0;
  bit          tx_calm;
  bit          rx_calm;

  // Directed words. Shifts typed in by hand where they are obvious: the
  // first tick after reset sees a black panel, and the tick after a full
  // white top pixel and a one/zero/three bottom pixel is plain to read.
  stim_row_t dir_table [DIR_WORDS] = '{
    '{lmsd_pkg::OP_TICK,  5'd31, 4'd15, 8'd255, 8'd255, 8'd255, 1'b1,
      '{3'd0, 3'd0, 3'd0, 5'd0, 1'b0, 1'b0}},
    '{lmsd_pkg::OP_WRITE, 5'd1,  4'd0,  8'd255, 8'd255, 8'd255, 1'b0, '0},
    '{lmsd_pkg::OP_WRITE, 5'd1,  4'd8,  8'd64,  8'd63,  8'd192, 1'b0, '0},
    '{lmsd_pkg::OP_TICK,  5'd0,  4'd0,  8'd0,   8'd0,   8'd0,   1'b1,
      '{3'd7, 3'd5, 3'd0, 5'd1, 1'b0, 1'b0}},
    '{lmsd_pkg::OP_WRITE, 5'd2,  4'd0,  8'd127, 8'd128, 8'd0,   1'b0, '0},
    '{lmsd_pkg::OP_WRITE, 5'd2,  4'd15, 8'd191, 8'd192, 8'd255, 1'b0, '0},
    '{lmsd_pkg::OP_WRITE, 5'd3,  4'd8,  8'd0,   8'd0,   8'd0,   1'b0, '0},
    '{lmsd_pkg::OP_TICK,  5'd17, 4'd9,  8'd170, 8'd85,  8'd15,  1'b0, '0},
    '{lmsd_pkg::OP_WRITE, 5'd3,  4'd0,  8'd255, 8'd0,   8'd0,   1'b0, '0},
    '{lmsd_pkg::OP_TICK,  5'd10, 4'd6,  8'd85,  8'd170, 8'd240, 1'b0, '0},
    '{lmsd_pkg::OP_WRITE, 5'd0,  4'd15, 8'd0,   8'd255, 8'd0,   1'b0, '0},
    '{lmsd_pkg::OP_WRITE, 5'd31, 4'd0,  8'd0,   8'd0,   8'd255, 1'b0, '0},
    '{lmsd_pkg::OP_WRITE, 5'd31, 4'd8,  8'd255, 8'd255, 8'd0,   1'b0, '0},
    '{lmsd_pkg::OP_WRITE, 5'd4,  4'd8,  8'd192, 8'd128, 8'd64,  1'b0, '0},
    '{lmsd_pkg::OP_TICK,  5'd0,  4'd0,  8'd0,   8'd0,   8'd0,   1'b0, '0},
    '{lmsd_pkg::OP_WRITE, 5'd1,  4'd0,  8'd0,   8'd0,   8'd0,   1'b0, '0},
    '{lmsd_pkg::OP_TICK,  5'd31, 4'd15, 8'd255, 8'd255, 8'd255, 1'b0, '0}
  };

  led_matrix_pwm_scan_driver_unit #(
    .PANEL_COLUMNS(PANEL_COLUMNS),
    .HALF_ROWS    (HALF_ROWS),
    .COLOR_BITS   (COLOR_BITS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_column_x     (in_column_x),
    .in_row_y        (in_row_y),
    .in_red_level    (in_red_level),
    .in_green_level  (in_green_level),
    .in_blue_level   (in_blue_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_top_rgb     (out_top_rgb),
    .out_bottom_rgb  (out_bottom_rgb),
    .out_row_address (out_row_address),
    .out_shift_column(out_shift_column),
    .out_latch_row   (out_latch_row),
    .out_frame_end   (out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: far beyond the clear sweep plus every word under worst stalls.
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Keep the top COLOR_BITS bits of an 8-bit level.
  function automatic logic [COLOR_BITS-1:0] cut_level(
    logic [lmsd_pkg::LEVEL_W-1:0] lvl);
    return COLOR_BITS'(lvl >> (lmsd_pkg::LEVEL_W - COLOR_BITS));
  endfunction

  // Light a pin when the stored level reaches the current PWM level.
  function automatic logic [lmsd_pkg::RGB_W-1:0] pin_code(
    pixel_t p, logic [COLOR_BITS-1:0] lvl);
    return {p.red >= lvl, p.green >= lvl, p.blue >= lvl};
  endfunction

  // Apply one accepted word to the shadow state; a tick yields one shift.
  task automatic scan_predict(input stim_row_t w, output bit has_shift,
                              output shift_word_t shift);
    int     idx;
    bit     last_col;
    bit     last_row;
    bit     last_lvl;
    pixel_t px;
    has_shift = 1'b0;
    shift     = '0;
    if (w.op == lmsd_pkg::OP_WRITE) begin
      // Drop writes that fall off the panel.
      if (w.x < PANEL_COLUMNS && w.y < 2 * HALF_ROWS) begin
        px.red   = cut_level(w.r);
        px.green = cut_level(w.g);
        px.blue  = cut_level(w.b);
        if (w.y < HALF_ROWS) begin
          top_shadow[w.y * PANEL_COLUMNS + w.x] = px;
        end else begin
          bottom_shadow[(w.y - HALF_ROWS) * PANEL_COLUMNS + w.x] = px;
        end
      end
    end else begin
      idx      = row_now * PANEL_COLUMNS + col_now;
      last_col = (col_now == PANEL_COLUMNS - 1);
      last_row = (row_now == HALF_ROWS - 1);
      last_lvl = (pwm_now == PWM_TOP);
      has_shift       = 1'b1;
      shift.top       = pin_code(top_shadow[idx], pwm_now);
      shift.bottom    = pin_code(bottom_shadow[idx], pwm_now);
      shift.row       = row_now;
      shift.col       = col_now;
      shift.latch     = last_col;
      shift.frame_end = last_col && last_row && last_lvl;
      // Advance column first, then row, then PWM level.
      if (!last_col) begin
        col_now = col_now + 1'b1;
      end else begin
        col_now = '0;
        if (!last_row) begin
          row_now = row_now + 1'b1;
        end else begin
          row_now = '0;
          pwm_now = last_lvl ? COLOR_BITS'(1) : pwm_now + 1'b1;
        end
      end
    end
  endtask

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= SHOW_FAULTS) $display("%0t: %s", $realtime, msg);
  endfunction

  // Present one word at the falling edge, hold it until taken, then predict.
  task automatic send_word(input stim_row_t w);
    bit          has_shift;
    shift_word_t shift;
    @(negedge clk);
    while (!tx_calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= w.op;
    in_column_x    <= w.x;
    in_row_y       <= w.y;
    in_red_level   <= w.r;
    in_green_level <= w.g;
    in_blue_level  <= w.b;
    do @(posedge clk); while (in_stall);
    scan_predict(w, has_shift, shift);
    if (has_shift) pending_shifts.push_back(w.typed ? w.shift : shift);
  endtask

  // Hold the sender off until every predicted shift has come out.
  task automatic drain_shifts();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_shifts.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall at random about a fifth of the time, except in the calm window.
  always @(negedge clk) begin
    out_stall <= rst_n && !rx_calm && ($urandom_range(0, 99) < 20);
  end

  // Check every shift taken at a rising edge against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_shift = '{out_top_rgb, out_bottom_rgb, out_row_address,
                     out_shift_column, out_latch_row, out_frame_end};
      if (pending_shifts.size() == 0) begin
        note_fault($sformatf({"unexpected shift: top=%0d bot=%0d row=%0d col=%0d ",
                              "latch=%0b fe=%0b"},
                             seen_shift.top, seen_shift.bottom, seen_shift.row,
                             seen_shift.col, seen_shift.latch, seen_shift.frame_end));
      end else begin
        want_shift = pending_shifts.pop_front();
        if (seen_shift.top !== want_shift.top || seen_shift.bottom !== want_shift.bottom ||
            seen_shift.row !== want_shift.row || seen_shift.col !== want_shift.col ||
            seen_shift.latch !== want_shift.latch ||
            seen_shift.frame_end !== want_shift.frame_end) begin
          note_fault($sformatf({"shift mismatch: exp top=%0d bot=%0d row=%0d col=%0d ",
                                "latch=%0b fe=%0b, got top=%0d bot=%0d row=%0d col=%0d ",
                                "latch=%0b fe=%0b"},
                               want_shift.top, want_shift.bottom, want_shift.row,
                               want_shift.col, want_shift.latch, want_shift.frame_end,
                               seen_shift.top, seen_shift.bottom, seen_shift.row,
                               seen_shift.col, seen_shift.latch, seen_shift.frame_end));
        end
      end
    end
  end

  initial begin
    stim_row_t w;
    // Drive every input to a known value, hold reset, then release it at a falling edge.
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = 1'b0;
    in_column_x    = '0;
    in_row_y       = '0;
    in_red_level   = '0;
    in_green_level = '0;
    in_blue_level  = '0;
    tx_calm        = 1'b0;
    rx_calm        = 1'b0;
    for (int i = 0; i < HALF_PIXELS; i++) begin
      top_shadow[i]    = '0;
      bottom_shadow[i] = '0;
    end
    pwm_now = COLOR_BITS'(1);
    row_now = '0;
    col_now = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part; the clear sweep simply shows up as a long stall.
    for (int i = 0; i < DIR_WORDS; i++) send_word(dir_table[i]);
    drain_shifts();

    // Random part: mostly ticks so the scan wraps a full frame, with writes
    // aimed at the pixel about to be shifted half of the time.
    for (int n = 0; n < RAND_WORDS; n++) begin
      tx_calm = (n >= 400 && n < 700);
      rx_calm = (n >= 1100 && n < 1350);
      if (n == 900) drain_shifts();
      w.op    = ($urandom_range(0, 99) < 80) ? lmsd_pkg::OP_TICK : lmsd_pkg::OP_WRITE;
      w.x     = lmsd_pkg::X_W'($urandom);
      w.y     = lmsd_pkg::Y_W'($urandom);
      w.r     = lmsd_pkg::LEVEL_W'($urandom);
      w.g     = lmsd_pkg::LEVEL_W'($urandom);
      w.b     = lmsd_pkg::LEVEL_W'($urandom);
      w.typed = 1'b0;
      w.shift = '0;
      if (w.op == lmsd_pkg::OP_WRITE && $urandom_range(0, 1)) begin
        w.x = col_now;
        w.y = lmsd_pkg::Y_W'(row_now + ($urandom_range(0, 1) ? HALF_ROWS : 0));
      end
      send_word(w);
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // Release the bus, wait out the queue and let the pipeline settle.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_shifts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
